// ===== design/bba_pkg.sv =====
// shared types, constants and helper functions for the bitmap block allocator
package bba_pkg;

    localparam int BPR_DEF    = 64;
    localparam int NREG_DEF   = 64;

    localparam int SEG_W      = 31;
    localparam int RCNT_W     = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int MODE_W     = 2;
    localparam int BLK_W      = 32;
    localparam int STATUS_W   = 2;

    localparam logic [RCNT_W-1:0] RCNT_RESET = RCNT_W'(64);

    localparam logic [MODE_W-1:0] MODE_ALLOC  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FREE   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FORMAT = 2'd2;
    localparam logic [MODE_W-1:0] MODE_NOP    = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_SPACE  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_BLOCK = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_READY = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_SEG_START    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_COUNT = 2'd1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_FCHK,
        S_DIV,
        S_FUPD,
        S_FMT,
        S_RESP
    } state_t;

    function automatic logic [63:0] word_mask(input int bpr, input int w);
        int rem;
        rem = bpr - w * 64;
        if (rem >= 64)
            return '1;
        if (rem <= 0)
            return '0;
        return (64'd1 << rem) - 64'd1;
    endfunction

    function automatic logic [5:0] lowest_set(input logic [63:0] v);
        logic [5:0] idx;
        idx = '0;
        for (int i = 63; i >= 0; i--)
        begin
            if (v[i])
                idx = 6'(i);
        end
        return idx;
    endfunction

endpackage

// ===== design/bba_if.sv =====
// command, response and configuration channel interfaces
interface bba_cmd_if import bba_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [BLK_W-1:0]  block_to_free;
    modport source (output valid, mode, block_to_free, input ready);
    modport sink (input valid, mode, block_to_free, output ready);
endinterface

interface bba_rsp_if import bba_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [BLK_W-1:0]    block_number;
    modport source (output valid, status, block_number, input ready);
    modport sink (input valid, status, block_number, output ready);
endinterface

interface bba_cfg_if import bba_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== design/bba_ram.sv =====
// generic single write port ram with registered read
module bba_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata <= mem[raddr];
    end

endmodule

// ===== design/bba_div.sv =====
// divider by a constant using reciprocal multiplication; start is registered through stage1_reg and stage2_reg to done
module bba_div import bba_pkg::*; #(
    parameter int DIVISOR = 65,
    parameter int NW      = 12,
    parameter int QW      = 6
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [NW-1:0]              dividend,
    output logic                       done,
    output logic [QW-1:0]              quotient,
    output logic [$clog2(DIVISOR)-1:0] remainder
);

    localparam int RMW   = $clog2(DIVISOR);
    localparam int RECIP = int'((64'd1 << NW) / 64'(DIVISOR));
    localparam int RCW   = $clog2(RECIP + 1);
    localparam int PW    = NW + RCW;

    logic           stage1_reg;
    logic           stage2_reg;
    logic           done_reg;
    logic [NW-1:0]  x_reg;
    logic [PW-1:0]  prod_reg;
    logic [NW-1:0]  q_est_reg;
    logic [NW-1:0]  r_est_reg;
    logic [QW-1:0]  q_reg;
    logic [RMW-1:0] rem_reg;
    logic [NW-1:0]  q_est;
    logic [NW-1:0]  r_est;
    logic           over;

    // estimate is exact or one short
    assign q_est = NW'(prod_reg >> NW);
    assign r_est = x_reg - q_est * NW'(DIVISOR);
    assign over  = (r_est_reg >= NW'(DIVISOR));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage1_reg <= 1'b0;
            stage2_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            stage1_reg <= start;
            stage2_reg <= stage1_reg;
            done_reg   <= stage2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg    <= dividend;
            prod_reg <= PW'(dividend) * PW'(RECIP);
        end
        if (stage1_reg)
        begin
            q_est_reg <= q_est;
            r_est_reg <= r_est;
        end
        if (stage2_reg)
        begin
            if (over)
            begin
                q_reg   <= QW'(q_est_reg + NW'(1));
                rem_reg <= RMW'(r_est_reg - NW'(DIVISOR));
            end
            else
            begin
                q_reg   <= QW'(q_est_reg);
                rem_reg <= RMW'(r_est_reg);
            end
        end
    end

    assign done      = done_reg;
    assign quotient  = q_reg;
    assign remainder = rem_reg;

endmodule

// ===== design/bitmap_block_allocator.sv =====
// bitmap block allocator top level: command sequencer over bitmap and region memories
//
// channels: cmd carries mode and block_to_free, rsp returns status and
// block_number, cfg writes segment_start (index 0) and region_count (index 1).
// every beat on cmd yields exactly one beat on rsp, in order.
// allocate scans the bitmap words of the head region, one word read per cycle
// from the bitmap ram. free checks the range, finds the region in the
// reciprocal-multiply divider and clears the block's bit; a block out of
// range is answered without the divider. format clears NUM_REGIONS *
// ceil(BLOCKS_PER_REGION / 64) bitmap words, one bitmap word cleared per cycle.
// at reset the block is unformatted: every command except format answers
// not ready. segment_start resets to 0 and region_count to 64.
// results sit in an output register; a new command is taken while a result
// waits there. if the receiver stalls, the next result holds in the
// sequencer and cmd.ready stays low until the output register frees.
// cfg.ready is always high; write configuration only while idle.
module bitmap_block_allocator import bba_pkg::*; #(
    parameter int BLOCKS_PER_REGION = BPR_DEF,
    parameter int NUM_REGIONS       = NREG_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    bba_cfg_if.sink   cfg,
    bba_cmd_if.sink   cmd,
    bba_rsp_if.source rsp
);

    localparam int WORDS    = (BLOCKS_PER_REGION + 63) / 64;
    localparam int WW       = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int RW       = $clog2(NUM_REGIONS);
    localparam int CNTW     = $clog2(NUM_REGIONS + 1);
    localparam int CW       = $clog2(BLOCKS_PER_REGION + 1);
    localparam int RS       = BLOCKS_PER_REGION + 1;
    localparam int OW       = $clog2(NUM_REGIONS * RS);
    localparam int LIMW     = $clog2(NUM_REGIONS * RS + 1);
    localparam int REMW     = $clog2(RS);
    localparam int BW       = $clog2(BLOCKS_PER_REGION);
    localparam int BM_DEPTH = NUM_REGIONS * WORDS;
    localparam int BM_AW    = $clog2(BM_DEPTH);
    localparam int MW       = RW + CW;

    function automatic logic [BM_AW-1:0] bm_addr(input logic [RW-1:0] r,
                                                 input logic [WW-1:0] w);
        return BM_AW'(int'(r) * WORDS + int'(w));
    endfunction

    state_t state_reg, state_next;

    logic [SEG_W-1:0]    seg_reg;
    logic [RCNT_W-1:0]   rcnt_reg;
    logic                formatted_reg;
    logic [RW-1:0]       head_reg;
    logic [BLK_W-1:0]    blk_reg;
    logic [CNTW-1:0]     cnt_reg;
    logic [LIMW-1:0]     limit_reg;
    logic [BLK_W-1:0]    base_reg;
    logic [WW-1:0]       w_reg;
    logic [RW-1:0]       region_reg;
    logic [BW-1:0]       bit_reg;
    logic [STATUS_W-1:0] res_status_reg;
    logic [BLK_W-1:0]    res_block_reg;
    logic [RW-1:0]       fmt_r_reg;
    logic [WW-1:0]       fmt_w_reg;
    logic                rsp_valid_reg;
    logic [STATUS_W-1:0] rsp_status_reg;
    logic [BLK_W-1:0]    rsp_block_reg;

    logic             acc;
    logic [CNTW-1:0]  cnt_now;
    logic [63:0]      freebits;
    logic             found;
    logic [5:0]       pe;
    logic [CW-1:0]    meta_cnt;
    logic [RW-1:0]    meta_nxt;
    logic             meta_full;
    logic [32:0]      off;
    logic             off_bad;
    logic [5:0]       bit_lo;
    logic             bitset;
    logic             fmt_last_w;
    logic             fmt_last;
    logic             rsp_load;

    logic             bm_we, bm_re, meta_we, meta_re;
    logic [BM_AW-1:0] bm_waddr, bm_raddr;
    logic [63:0]      bm_wdata, bm_rdata;
    logic [RW-1:0]    meta_waddr, meta_raddr;
    logic [MW-1:0]    meta_wdata, meta_rdata;

    logic                head_we;
    logic [RW-1:0]       head_wdata;
    logic                res_we;
    logic [STATUS_W-1:0] res_status;
    logic [BLK_W-1:0]    res_block;

    logic                div_start, div_done;
    logic [OW-1:0]       div_dividend;
    logic [RW-1:0]       div_q;
    logic [REMW-1:0]     div_rem;

    assign acc       = cmd.valid && cmd.ready;
    assign cmd.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;

    always_comb
    begin
        if (rcnt_reg == '0)
            cnt_now = CNTW'(1);
        else if (32'(rcnt_reg) > 32'(NUM_REGIONS))
            cnt_now = CNTW'(NUM_REGIONS);
        else
            cnt_now = CNTW'(rcnt_reg);
    end

    assign freebits  = ~bm_rdata & word_mask(BLOCKS_PER_REGION, int'(w_reg));
    assign found     = |freebits;
    assign pe        = lowest_set(freebits);
    assign meta_cnt  = meta_rdata[CW-1:0];
    assign meta_nxt  = meta_rdata[MW-1:CW];
    assign meta_full = (meta_cnt == CW'(BLOCKS_PER_REGION));

    assign off          = {1'b0, blk_reg} - {2'b00, seg_reg};
    assign off_bad      = off[32] || (off[31:0] >= 32'(limit_reg));
    assign div_dividend = OW'(off[31:0]);

    assign bit_lo = 6'(bit_reg);
    assign bitset = bm_rdata[bit_lo];

    assign fmt_last_w = (fmt_w_reg == WW'(WORDS - 1));
    assign fmt_last   = fmt_last_w && (fmt_r_reg == RW'(NUM_REGIONS - 1));
    assign rsp_load   = (state_reg == S_RESP) && (!rsp_valid_reg || rsp.ready);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (acc)
                begin
                    if (cmd.mode == MODE_FORMAT)
                        state_next = S_FMT;
                    else if (!formatted_reg)
                        state_next = S_RESP;
                    else if (cmd.mode == MODE_ALLOC)
                        state_next = S_SCAN;
                    else if (cmd.mode == MODE_FREE)
                        state_next = S_FCHK;
                    else
                        state_next = S_RESP;
                end
            end
            S_SCAN:
            begin
                if (meta_full || found)
                    state_next = S_RESP;
            end
            S_FCHK:
            begin
                state_next = off_bad ? S_RESP : S_DIV;
            end
            S_DIV:
            begin
                if (div_done)
                    state_next = (div_rem == '0) ? S_RESP : S_FUPD;
            end
            S_FUPD:
            begin
                state_next = S_RESP;
            end
            S_FMT:
            begin
                if (fmt_last)
                    state_next = S_RESP;
            end
            S_RESP:
            begin
                if (rsp_load)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // memory controls and register loads
    always_comb
    begin
        bm_we      = 1'b0;
        bm_waddr   = bm_addr(region_reg, w_reg);
        bm_wdata   = bm_rdata;
        bm_re      = 1'b0;
        bm_raddr   = bm_addr(head_reg, '0);
        meta_we    = 1'b0;
        meta_waddr = region_reg;
        meta_wdata = meta_rdata;
        meta_re    = 1'b0;
        meta_raddr = head_reg;
        head_we    = 1'b0;
        head_wdata = meta_nxt;
        res_we     = 1'b0;
        res_status = ST_OK;
        res_block  = '0;
        div_start  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (acc && cmd.mode != MODE_FORMAT)
                begin
                    if (!formatted_reg)
                    begin
                        res_we     = 1'b1;
                        res_status = ST_NOT_READY;
                    end
                    else if (cmd.mode == MODE_ALLOC)
                    begin
                        bm_re   = 1'b1;
                        meta_re = 1'b1;
                    end
                    else if (cmd.mode == MODE_NOP)
                        res_we = 1'b1;
                end
            end
            S_SCAN:
            begin
                if (meta_full)
                begin
                    res_we     = 1'b1;
                    res_status = ST_NO_SPACE;
                end
                else if (found)
                begin
                    bm_we      = 1'b1;
                    bm_wdata   = bm_rdata | (64'd1 << pe);
                    meta_we    = 1'b1;
                    meta_wdata = {meta_nxt, CW'(meta_cnt + CW'(1))};
                    head_we    = (meta_cnt + CW'(1)) == CW'(BLOCKS_PER_REGION);
                    res_we     = 1'b1;
                    res_block  = base_reg + (32'(w_reg) << 6) + 32'(pe);
                end
                else
                begin
                    bm_re    = 1'b1;
                    bm_raddr = bm_addr(region_reg, WW'(w_reg + WW'(1)));
                end
            end
            S_FCHK:
            begin
                if (off_bad)
                begin
                    res_we     = 1'b1;
                    res_status = ST_BAD_BLOCK;
                end
                else
                    div_start = 1'b1;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    if (div_rem == '0)
                    begin
                        res_we     = 1'b1;
                        res_status = ST_BAD_BLOCK;
                    end
                    else
                    begin
                        bm_re      = 1'b1;
                        bm_raddr   = bm_addr(div_q,
                            WW'(32'(BW'(div_rem - REMW'(1))) >> 6));
                        meta_re    = 1'b1;
                        meta_raddr = div_q;
                    end
                end
            end
            S_FUPD:
            begin
                res_we   = 1'b1;
                bm_waddr = bm_addr(region_reg, WW'(32'(bit_reg) >> 6));
                if (bitset)
                begin
                    bm_we      = 1'b1;
                    bm_wdata   = bm_rdata & ~(64'd1 << bit_lo);
                    meta_we    = 1'b1;
                    meta_wdata = {(meta_full ? head_reg : meta_nxt),
                                  CW'(meta_cnt - CW'(1))};
                    head_we    = meta_full;
                    head_wdata = region_reg;
                end
            end
            S_FMT:
            begin
                bm_we      = 1'b1;
                bm_waddr   = bm_addr(fmt_r_reg, fmt_w_reg);
                bm_wdata   = '0;
                meta_we    = (fmt_w_reg == '0);
                meta_waddr = fmt_r_reg;
                if ((32'(fmt_r_reg) + 32'd1) < 32'(cnt_reg))
                    meta_wdata = {RW'(fmt_r_reg + RW'(1)), CW'(0)};
                else
                    meta_wdata = {fmt_r_reg, CW'(0)};
                if (fmt_last)
                begin
                    head_we    = 1'b1;
                    head_wdata = '0;
                    res_we     = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            seg_reg       <= '0;
            rcnt_reg      <= RCNT_RESET;
            formatted_reg <= 1'b0;
            head_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    CFG_SEG_START:    seg_reg  <= cfg.data[SEG_W-1:0];
                    CFG_REGION_COUNT: rcnt_reg <= cfg.data[RCNT_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            if (state_reg == S_FMT && fmt_last)
                formatted_reg <= 1'b1;
            if (head_we)
                head_reg <= head_wdata;
            if (rsp_load)
                rsp_valid_reg <= 1'b1;
            else if (rsp.ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            blk_reg    <= cmd.block_to_free;
            cnt_reg    <= cnt_now;
            limit_reg  <= LIMW'(int'(cnt_now) * RS);
            base_reg   <= 32'(seg_reg) + 32'(head_reg) * 32'(RS) + 32'd1;
            w_reg      <= '0;
            region_reg <= head_reg;
            fmt_r_reg  <= '0;
            fmt_w_reg  <= '0;
        end
        if (state_reg == S_SCAN && !meta_full && !found)
            w_reg <= WW'(w_reg + WW'(1));
        if (state_reg == S_DIV && div_done)
        begin
            region_reg <= div_q;
            bit_reg    <= BW'(div_rem - REMW'(1));
        end
        if (state_reg == S_FMT)
        begin
            if (fmt_last_w)
            begin
                fmt_w_reg <= '0;
                if (!fmt_last)
                    fmt_r_reg <= RW'(fmt_r_reg + RW'(1));
            end
            else
                fmt_w_reg <= WW'(fmt_w_reg + WW'(1));
        end
        if (res_we)
        begin
            res_status_reg <= res_status;
            res_block_reg  <= res_block;
        end
        if (rsp_load)
        begin
            rsp_status_reg <= res_status_reg;
            rsp_block_reg  <= res_block_reg;
        end
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.status       = rsp_status_reg;
    assign rsp.block_number = rsp_block_reg;

    bba_ram #(
        .WIDTH (64),
        .DEPTH (BM_DEPTH)
    ) u_bitmap_ram (
        .clk   (clk),
        .we    (bm_we),
        .waddr (bm_waddr),
        .wdata (bm_wdata),
        .re    (bm_re),
        .raddr (bm_raddr),
        .rdata (bm_rdata)
    );

    bba_ram #(
        .WIDTH (MW),
        .DEPTH (NUM_REGIONS)
    ) u_region_ram (
        .clk   (clk),
        .we    (meta_we),
        .waddr (meta_waddr),
        .wdata (meta_wdata),
        .re    (meta_re),
        .raddr (meta_raddr),
        .rdata (meta_rdata)
    );

    bba_div #(
        .DIVISOR (RS),
        .NW      (OW),
        .QW      (RW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_rem)
    );

    // no memory write before format has started
    a_write_needs_format: assert property (@(posedge clk) disable iff (!rst_n)
        (bm_we || meta_we) |-> (formatted_reg || state_reg == S_FMT))
        else $error("memory write while unformatted");

    // divider finishes only while the sequencer waits for it
    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV))
        else $error("divider done outside divide state");

    // used count of the head region never exceeds the region size
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (32'(meta_cnt) <= 32'(BLOCKS_PER_REGION)))
        else $error("region used count out of range");

    // head moves only on allocate, free or format
    a_head_change: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(head_reg) |-> ($past(state_reg) == S_SCAN
            || $past(state_reg) == S_FUPD || $past(state_reg) == S_FMT))
        else $error("head region changed unexpectedly");

endmodule

// ===== verif/tb_bitmap_block_allocator.sv =====
`timescale 1ns / 1ps
// testbench for bitmap_block_allocator: directed and random commands checked beat by beat
module tb_bitmap_block_allocator;
    import bba_pkg::*;

    localparam int BPR        = BPR_DEF;
    localparam int NREG       = NREG_DEF;
    localparam int REGION_SZ  = BPR + 1;
    localparam int IDLE_LIMIT = 5000;
    localparam int SETTLE     = 2 * NREG + 20;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [BLK_W-1:0]    block_number;
    } reply_t;

    logic clk;
    logic rst_n;

    bba_cfg_if cfg_bus ();
    bba_cmd_if cmd_bus ();
    bba_rsp_if rsp_bus ();

    bitmap_block_allocator u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_bus),
        .cmd   (cmd_bus),
        .rsp   (rsp_bus)
    );

    // allocator image kept by the bench
    logic [BPR-1:0]    used_map [NREG];
    logic [5:0]        succ_region [NREG];
    logic [5:0]        head_reg;
    logic              is_formatted;
    logic [SEG_W-1:0]  seg_base;
    logic [RCNT_W-1:0] rcount;

    reply_t owed_replies [$];
    int     errors;
    bit     src_gaps;
    bit     sink_gaps;
    int     sink_hold_len;
    int     quiet_cycles = 0;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic int unsigned regions_active();
        if (rcount == '0)
            return 1;
        if (rcount > NREG)
            return NREG;
        return 32'(rcount);
    endfunction

    function automatic logic [BLK_W-1:0] seg_block(input int unsigned off);
        return BLK_W'(64'(seg_base) + 64'(off));
    endfunction

    function automatic reply_t run_allocator_cmd(input logic [MODE_W-1:0] m,
                                                 input logic [BLK_W-1:0] b);
        reply_t          rep;
        int unsigned     cnt;
        int unsigned     ridx;
        int unsigned     bidx;
        longint unsigned off;
        bit              found;
        cnt = regions_active();
        rep.status = ST_OK;
        rep.block_number = '0;
        found = 1'b0;
        bidx = 0;
        if (m == MODE_FORMAT)
        begin
            for (int i = 0; i < NREG; i++)
            begin
                used_map[i] = '0;
                succ_region[i] = (32'(i) + 1 < cnt) ? 6'(i + 1) : 6'(i);
            end
            head_reg = '0;
            is_formatted = 1'b1;
        end
        else if (!is_formatted)
            rep.status = ST_NOT_READY;
        else if (m == MODE_ALLOC)
        begin
            ridx = 32'(head_reg);
            for (int i = BPR - 1; i >= 0; i--)
            begin
                if (!used_map[ridx][i])
                begin
                    found = 1'b1;
                    bidx = 32'(i);
                end
            end
            if (!found)
                rep.status = ST_NO_SPACE;
            else
            begin
                used_map[ridx][bidx] = 1'b1;
                if (&used_map[ridx])
                    head_reg = succ_region[ridx];
                rep.block_number = BLK_W'(64'(seg_base) + 64'(ridx) * 64'(REGION_SZ)
                                          + 64'(bidx) + 64'd1);
            end
        end
        else if (m == MODE_FREE)
        begin
            off = 64'(b) - 64'(seg_base);
            if (b < seg_base || off >= 64'(cnt) * 64'(REGION_SZ)
                || off % 64'(REGION_SZ) == 64'd0)
                rep.status = ST_BAD_BLOCK;
            else
            begin
                ridx = 32'(off / 64'(REGION_SZ));
                bidx = 32'(off % 64'(REGION_SZ)) - 1;
                // a full region goes back on the front of the chain
                if (&used_map[ridx])
                begin
                    succ_region[ridx] = head_reg;
                    head_reg = 6'(ridx);
                end
                used_map[ridx][bidx] = 1'b0;
            end
        end
        return rep;
    endfunction

    function automatic bit pick_used_block(output logic [BLK_W-1:0] blk);
        int unsigned total;
        int unsigned start;
        int unsigned idx;
        total = regions_active() * BPR;
        start = $urandom_range(0, total - 1);
        blk = '0;
        for (int unsigned n = 0; n < total; n++)
        begin
            idx = (start + n) % total;
            if (is_formatted && used_map[idx / BPR][idx % BPR])
            begin
                blk = seg_block((idx / BPR) * REGION_SZ + idx % BPR + 1);
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    task automatic send_cmd(input logic [MODE_W-1:0] m, input logic [BLK_W-1:0] b);
        if (src_gaps && $urandom_range(0, 3) == 0)
        begin
            cmd_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        cmd_bus.valid <= 1'b1;
        cmd_bus.mode <= m;
        cmd_bus.block_to_free <= b;
        do
            @(posedge clk);
        while (cmd_bus.ready !== 1'b1);
        owed_replies.push_back(run_allocator_cmd(m, b));
    endtask

    task automatic settle_idle();
        cmd_bus.valid <= 1'b0;
        while (owed_replies.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_config(input logic [SEG_W-1:0] seg, input logic [RCNT_W-1:0] cnt);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= CFG_SEG_START;
        cfg_bus.data <= {1'($urandom()), seg};
        do
            @(posedge clk);
        while (cfg_bus.ready !== 1'b1);
        seg_base = seg;
        cfg_bus.index <= CFG_REGION_COUNT;
        cfg_bus.data <= {25'($urandom()), cnt};
        do
            @(posedge clk);
        while (cfg_bus.ready !== 1'b1);
        rcount = cnt;
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic test_unformatted();
        set_config(31'h0000_0100, 7'd3);
        send_cmd(MODE_ALLOC, '0);
        send_cmd(MODE_FREE, 32'h0000_0102);
        send_cmd(MODE_NOP, '1);
        settle_idle();
    endtask

    task automatic test_free_checks();
        send_cmd(MODE_FORMAT, '0);
        repeat (3) send_cmd(MODE_ALLOC, '0);
        send_cmd(MODE_FREE, seg_block(0) - 1);
        send_cmd(MODE_FREE, seg_block(0));
        send_cmd(MODE_FREE, seg_block(REGION_SZ));
        send_cmd(MODE_FREE, seg_block(3 * REGION_SZ));
        send_cmd(MODE_FREE, seg_block(3 * REGION_SZ - 1));
        send_cmd(MODE_FREE, '1);
        send_cmd(MODE_FREE, '0);
        send_cmd(MODE_FREE, seg_block(2));
        send_cmd(MODE_FREE, seg_block(2));
        send_cmd(MODE_NOP, '0);
        send_cmd(MODE_ALLOC, '0);
        send_cmd(MODE_FORMAT, '0);
        send_cmd(MODE_ALLOC, '0);
        settle_idle();
    endtask

    task automatic test_head_region_full();
        // zero regions acts as one, so the only region points to itself
        set_config(31'h7FFF_FFFF, 7'd0);
        send_cmd(MODE_FORMAT, '0);
        repeat (BPR) send_cmd(MODE_ALLOC, '0);
        send_cmd(MODE_ALLOC, '0);
        send_cmd(MODE_FREE, seg_block(5));
        send_cmd(MODE_ALLOC, '0);
        send_cmd(MODE_ALLOC, '0);
        send_cmd(MODE_FREE, seg_block(REGION_SZ + 1));
        settle_idle();
        set_config('0, 7'd127);
        send_cmd(MODE_FORMAT, '0);
        send_cmd(MODE_FREE, seg_block(NREG * REGION_SZ - 1));
        send_cmd(MODE_FREE, seg_block(NREG * REGION_SZ));
        send_cmd(MODE_ALLOC, '0);
        settle_idle();
    endtask

    task automatic test_output_backpressure();
        logic [BLK_W-1:0] b;
        src_gaps = 1'b0;
        sink_hold_len = 120;
        for (int i = 0; i < 24; i++)
        begin
            if (i % 3 == 2 && pick_used_block(b))
                send_cmd(MODE_FREE, b);
            else
                send_cmd(MODE_ALLOC, $urandom());
        end
        settle_idle();
        src_gaps = 1'b1;
    endtask

    task automatic random_phase(input logic [SEG_W-1:0] seg, input logic [RCNT_W-1:0] cnt,
                                input int n, input int alloc_pct);
        logic [BLK_W-1:0] b;
        int unsigned      roll;
        set_config(seg, cnt);
        send_cmd(MODE_FORMAT, $urandom());
        for (int i = 0; i < n; i++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < alloc_pct)
                send_cmd(MODE_ALLOC, $urandom());
            else
            begin
                roll = $urandom_range(0, 99);
                if (roll < 55 && pick_used_block(b))
                    send_cmd(MODE_FREE, b);
                else if (roll < 75)
                    send_cmd(MODE_FREE,
                             seg_block($urandom_range(0, regions_active() * REGION_SZ - 1)));
                else if (roll < 87)
                    send_cmd(MODE_FREE, $urandom());
                else if (roll < 97)
                    send_cmd(MODE_NOP, $urandom());
                else
                    send_cmd(MODE_FORMAT, $urandom());
            end
        end
        settle_idle();
    endtask

    task automatic test_random_traffic();
        random_phase(31'($urandom()), 7'd2, 90, 85);
        random_phase('0, 7'd1, 50, 80);
        random_phase(31'($urandom()), 7'd0, 35, 60);
        random_phase(31'h7FFF_FFFF, 7'd127, 40, 60);
        random_phase(31'($urandom()), 7'd64, 40, 55);
        random_phase(31'($urandom()), 7'($urandom_range(3, 8)), 50, 70);
        src_gaps = 1'b0;
        sink_gaps = 1'b0;
        random_phase(31'($urandom_range(0, 1000)), 7'd1, 50, 75);
    endtask

    task automatic finish_run();
        settle_idle();
        repeat (SETTLE) @(posedge clk);
        if (errors == 0 && owed_replies.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    endtask

    initial
    begin : rsp_ready_drive
        int held;
        rsp_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (sink_hold_len > 0)
            begin
                held = sink_hold_len;
                sink_hold_len = 0;
                rsp_bus.ready <= 1'b0;
                repeat (held) @(posedge clk);
                rsp_bus.ready <= 1'b1;
            end
            else if (sink_gaps && $urandom_range(0, 5) == 0)
            begin
                rsp_bus.ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge clk);
                rsp_bus.ready <= 1'b1;
            end
            else
                rsp_bus.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : reply_check
        reply_t want;
        if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)
        begin
            if (owed_replies.size() == 0)
            begin
                $display("%0t: reply beat with none pending: expected none, actual status %0d block %0h",
                         $time, rsp_bus.status, rsp_bus.block_number);
                errors++;
            end
            else
            begin
                want = owed_replies.pop_front();
                if (rsp_bus.status !== want.status)
                begin
                    $display("%0t: status mismatch: expected %0d, actual %0d",
                             $time, want.status, rsp_bus.status);
                    errors++;
                end
                if (rsp_bus.block_number !== want.block_number)
                begin
                    $display("%0t: block_number mismatch: expected %0h, actual %0h",
                             $time, want.block_number, rsp_bus.block_number);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((cmd_bus.valid & cmd_bus.ready) === 1'b1 || (rsp_bus.valid & rsp_bus.ready) === 1'b1
            || (cfg_bus.valid & cfg_bus.ready) === 1'b1)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        errors = 0;
        src_gaps = 1'b1;
        sink_gaps = 1'b1;
        sink_hold_len = 0;
        seg_base = '0;
        rcount = RCNT_RESET;
        head_reg = '0;
        is_formatted = 1'b0;
        for (int i = 0; i < NREG; i++)
        begin
            used_map[i] = '0;
            succ_region[i] = '0;
        end
        rst_n <= 1'b0;
        cmd_bus.valid <= 1'b0;
        cmd_bus.mode <= MODE_NOP;
        cmd_bus.block_to_free <= '0;
        cfg_bus.valid <= 1'b0;
        cfg_bus.index <= CFG_SEG_START;
        cfg_bus.data <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        test_unformatted();
        test_free_checks();
        test_head_region_full();
        test_output_backpressure();
        test_random_traffic();
        finish_run();
    end

endmodule

// ===== files.f =====
design/bba_pkg.sv
design/bba_if.sv
design/bba_ram.sv
design/bba_div.sv
design/bitmap_block_allocator.sv
verif/tb_bitmap_block_allocator.sv
